// ===== hdl/cisamp_pkg.sv =====
// Shared constants and types for the challenge index sampler.
package cisamp_pkg;

  localparam int PolySize = 512;
  localparam int IdxW     = $clog2(PolySize);
  localparam int ColW     = 4;
  localparam int RowW     = 1 << ColW;
  localparam int RowCnt   = PolySize / RowW;
  localparam int RowAw    = IdxW - ColW;
  localparam int WordW    = 16;
  localparam int KappaW   = 7;
  localparam int PosW     = 6;

  localparam logic [KappaW-1:0] KappaReset = 7'd23;
  localparam logic [KappaW-1:0] KappaMin   = 7'd1;
  localparam logic [KappaW-1:0] KappaMax   = 7'd64;

  localparam logic FuncDigest = 1'b0;
  localparam logic FuncStart  = 1'b1;

  typedef struct packed {
    logic             en;
    logic [RowAw-1:0] row;
    logic [RowW-1:0]  data;
  } seen_wr_t;

endpackage

// ===== hdl/cisamp_seen_map.sv =====
// Bitmap of chosen indices: row memory with per-row valid bits and write bypass.
module cisamp_seen_map
  import cisamp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [RowAw-1:0] rd_row_i,
  input  seen_wr_t         wr_i,
  input  logic             clear_i,
  output logic [RowW-1:0]  row_o
);

  logic [RowW-1:0]   mem [RowCnt];
  logic [RowW-1:0]   rd_q;
  logic [RowAw-1:0]  rd_row_q;
  logic [RowW-1:0]   byp_data_q;
  logic              byp_q;
  logic [RowCnt-1:0] rowvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.row] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_row_i];
      rd_row_q   <= rd_row_i;
      byp_data_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rowvld_q <= '0;
      byp_q    <= 1'b0;
    end else begin
      if (clear_i) begin
        rowvld_q <= '0;
      end else if (wr_i.en) begin
        rowvld_q[wr_i.row] <= 1'b1;
      end
      if (rd_en_i) begin
        byp_q <= wr_i.en && (wr_i.row == rd_row_i);
      end
    end
  end

  // A row written in the same cycle as the read takes the new data; an
  // unwritten row reads as empty.
  assign row_o = byp_q ? byp_data_q : (rowvld_q[rd_row_q] ? rd_q : '0);

endmodule

// ===== hdl/challenge_index_sampler_core.sv =====
// Top level of the challenge index sampler.
//
//  Channel  Direction  Handshake              Payload
//  in       sink       in_valid_i/in_stall_o  in_func_i, in_digest_word_i
//  out      source     out_valid_o/out_stall_i out_index_o, out_position_o, out_last_o
//  cfg      sink       cfg_valid_i/cfg_ready_o cfg_data_i (kappa)
//
// One transaction is accepted per cycle while the input is not stalled; the bitmap
// row is read as the input stage loads, and the check and update then fill the
// output register with each newly chosen index once the output register is free.
// Reset clears the bitmap valid bits, the count, the finished flag and kappa to 23.
// A stall on the output holds the output register and, once the input stage is
// also full, stalls the input. cfg_ready_o is always high.
module challenge_index_sampler_core
  import cisamp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_func_i,
  input  logic [WordW-1:0]  in_digest_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IdxW-1:0]   out_index_o,
  output logic [PosW-1:0]   out_position_o,
  output logic              out_last_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [KappaW-1:0] cfg_data_i
);

  logic              s1_valid_q;
  logic              s1_func_q;
  logic [IdxW-1:0]   s1_idx_q;
  logic [KappaW-1:0] kappa_q;
  logic [KappaW-1:0] count_q;
  logic [KappaW-1:0] count_d;
  logic              finished_q;
  logic              out_valid_q;
  logic [IdxW-1:0]   out_index_q;
  logic [PosW-1:0]   out_position_q;
  logic              out_last_q;

  logic              in_accept;
  logic              out_free;
  logic              advance;
  logic              newly;
  logic              is_last;
  logic [KappaW-1:0] kappa_eff;
  logic [RowW-1:0]   row;
  logic [RowW-1:0]   bit_mask;
  seen_wr_t          seen_wr;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (kappa_q < KappaMin) begin
      kappa_eff = KappaMin;
    end else if (kappa_q > KappaMax) begin
      kappa_eff = KappaMax;
    end else begin
      kappa_eff = kappa_q;
    end
  end

  assign bit_mask = RowW'(1) << s1_idx_q[ColW-1:0];
  assign newly    = (s1_func_q == FuncDigest) && !finished_q && !row[s1_idx_q[ColW-1:0]];
  assign count_d  = count_q + KappaW'(1);
  assign is_last  = count_d >= kappa_eff;

  assign seen_wr.en   = advance && newly;
  assign seen_wr.row  = s1_idx_q[IdxW-1:ColW];
  assign seen_wr.data = row | bit_mask;

  cisamp_seen_map u_seen_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_accept),
    .rd_row_i (in_digest_word_i[IdxW-1:ColW]),
    .wr_i     (seen_wr),
    .clear_i  (advance && (s1_func_q == FuncStart)),
    .row_o    (row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      kappa_q     <= KappaReset;
      count_q     <= '0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        kappa_q <= cfg_data_i;
      end
      if (advance) begin
        if (s1_func_q == FuncStart) begin
          count_q    <= '0;
          finished_q <= 1'b0;
        end else if (newly) begin
          count_q    <= count_d;
          finished_q <= is_last;
        end
      end
      if (out_free) begin
        out_valid_q <= advance && newly;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q <= in_func_i;
      s1_idx_q  <= in_digest_word_i[IdxW-1:0];
    end
    if (advance && newly) begin
      out_index_q    <= s1_idx_q;
      out_position_q <= count_q[PosW-1:0];
      out_last_q     <= is_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_index_o    = out_index_q;
  assign out_position_o = out_position_q;
  assign out_last_o     = out_last_q;

endmodule

// ===== hdl/cisamp_checker.sv =====
// Port-level assertions for the challenge index sampler, bound to the top level.
module cisamp_checker
  import cisamp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [IdxW-1:0]   out_index_o,
  input logic [PosW-1:0]   out_position_o,
  input logic              out_last_o,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic [KappaW-1:0] cfg_data_i
);

  logic [KappaW-1:0] kappa_q;
  logic [KappaW-1:0] kappa_eff;
  logic [KappaW-1:0] pos_next;
  logic              last_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kappa_q     <= KappaReset;
      last_seen_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        kappa_q <= cfg_data_i;
      end
      if (out_valid_o && !out_stall_i) begin
        last_seen_q <= out_last_o;
      end
    end
  end

  assign kappa_eff = (kappa_q < KappaMin) ? KappaMin :
                     ((kappa_q > KappaMax) ? KappaMax : kappa_q);
  assign pos_next  = KappaW'(out_position_o) + KappaW'(1);

  // The output holds its transaction while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_index_o)
      && $stable(out_position_o) && $stable(out_last_o))
    else $error("output transaction changed while stalled");

  // The input only stalls behind a full, stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output could move");

  // The last flag matches the slot against the effective kappa.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_last_o == (pos_next >= kappa_eff)))
    else $error("last flag does not match position and kappa");

  // After a completed challenge the next index starts a new list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_seen_q |-> out_position_o == '0)
    else $error("new challenge does not start at slot zero");

endmodule

bind challenge_index_sampler_core cisamp_checker u_cisamp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_index_o    (out_index_o),
  .out_position_o (out_position_o),
  .out_last_o     (out_last_o),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_o    (cfg_ready_o),
  .cfg_data_i     (cfg_data_i)
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the challenge index sampler core.
module tb_top;
  import cisamp_pkg::*;

  localparam int ItemTarget    = 1750;
  localparam int WatchdogLimit = 1000;
  localparam int SettleCycles  = 4;
  localparam int HoldOffCycles = 80;

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic [PosW-1:0] position;
    logic            last;
  } pick_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              in_func_i;
  logic [WordW-1:0]  in_digest_word_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [IdxW-1:0]   out_index_o;
  logic [PosW-1:0]   out_position_o;
  logic              out_last_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [KappaW-1:0] cfg_data_i;

  // Predicted state of the sampler.
  logic [PolySize-1:0] seen_map;
  logic [KappaW-1:0]   pick_count;
  logic                pick_done;
  logic [KappaW-1:0]   kappa_reg;
  pick_t               expected_picks[$];

  int  error_count;
  int  items_done;
  int  quiet_cycles;
  int  hold_cycles;
  int  rx_wait;
  bit  tx_idle_on;
  bit  rx_idle_on;

  challenge_index_sampler_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_func_i        (in_func_i),
    .in_digest_word_i (in_digest_word_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_index_o      (out_index_o),
    .out_position_o   (out_position_o),
    .out_last_o       (out_last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void track_item(logic func, logic [WordW-1:0] word);
    logic [IdxW-1:0]   idx;
    logic [KappaW-1:0] eff_kappa;
    pick_t             pick;
    if (func == FuncStart) begin
      seen_map   = '0;
      pick_count = '0;
      pick_done  = 1'b0;
    end else if (!pick_done) begin
      idx = IdxW'(word % PolySize);
      if (!seen_map[idx]) begin
        seen_map[idx] = 1'b1;
        if (kappa_reg == 0) begin
          eff_kappa = KappaMin;
        end else if (kappa_reg > KappaMax) begin
          eff_kappa = KappaMax;
        end else begin
          eff_kappa = kappa_reg;
        end
        pick.index    = idx;
        pick.position = pick_count[PosW-1:0];
        pick_count    = pick_count + 1'b1;
        pick.last     = (pick_count >= eff_kappa);
        pick_done     = pick.last;
        expected_picks.push_back(pick);
      end
    end
  endfunction

  task automatic send_item(input logic func, input logic [WordW-1:0] word);
    int gap;
    bit taken;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    in_func_i        = func;
    in_digest_word_i = word;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
    end
    if (func == FuncStart || !pick_done) begin
      items_done++;
    end
    track_item(func, word);
  endtask

  // Waits until every expected result has arrived and the pipeline is empty.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_picks.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_kappa(input logic [KappaW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    kappa_reg = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_challenge();
    logic [WordW-1:0] word;
    logic [WordW-1:0] recent;
    int               roll;
    int               guard;
    send_item(FuncStart, WordW'($urandom));
    recent = WordW'($urandom);
    guard  = 0;
    while (!pick_done && guard < 400) begin
      roll = $urandom_range(0, 99);
      if (roll < 1) begin
        send_item(FuncStart, WordW'($urandom));
      end else if (roll < 16) begin
        send_item(FuncDigest, recent + WordW'(PolySize * $urandom_range(0, 127)));
      end else begin
        word = WordW'($urandom);
        send_item(FuncDigest, word);
        recent = word;
      end
      guard++;
    end
    repeat ($urandom_range(0, 3)) send_item(FuncDigest, WordW'($urandom));
  endtask

  task automatic test_directed();
    send_item(FuncStart, 16'hFFFF);
    send_item(FuncDigest, 16'h0000);
    send_item(FuncDigest, 16'hFFFF);
    send_item(FuncDigest, 16'h0200);
    send_item(FuncDigest, 16'h8001);
    send_item(FuncDigest, 16'h01FF);
    send_item(FuncDigest, 16'hAA55);
    settle();
    write_kappa(KappaMin);
    send_item(FuncStart, 16'h0000);
    send_item(FuncDigest, 16'h1234);
    send_item(FuncDigest, 16'h4321);
    send_item(FuncStart, 16'h5A5A);
    send_item(FuncDigest, 16'h1234);
    settle();
    write_kappa(7'd0);
    send_item(FuncStart, 16'h0000);
    send_item(FuncDigest, 16'h7E01);
    send_item(FuncDigest, 16'h0002);
    settle();
    write_kappa(7'd5);
    send_item(FuncStart, 16'hA5A5);
    send_item(FuncDigest, 16'h0010);
    send_item(FuncDigest, 16'h0020);
    send_item(FuncDigest, 16'h0030);
    settle();
    write_kappa(7'd2);
    send_item(FuncDigest, 16'h0040);
    send_item(FuncDigest, 16'h0050);
    settle();
  endtask

  task automatic test_kappa_extremes();
    write_kappa(KappaMax);
    run_challenge();
    settle();
    write_kappa(7'd65);
    run_challenge();
    settle();
    write_kappa(7'd127);
    run_challenge();
    settle();
  endtask

  task automatic test_backpressure();
    int i;
    write_kappa(KappaMax);
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    send_item(FuncStart, 16'h0000);
    hold_cycles = HoldOffCycles;
    for (i = 0; i < 40; i++) begin
      send_item(FuncDigest, WordW'(i * 11 + 3));
    end
    settle();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random_challenges();
    logic [KappaW-1:0] value;
    while (items_done < ItemTarget) begin
      if ($urandom_range(0, 9) == 0) begin
        value = ($urandom_range(0, 1) == 0) ? 7'd0 : KappaW'($urandom_range(65, 127));
      end else begin
        value = KappaW'($urandom_range(1, 64));
      end
      write_kappa(value);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 5)) run_challenge();
      settle();
    end
  endtask

  // Receiver: random stall before each result, plus a long hold-off set by the backpressure test.
  always begin
    if (hold_cycles > 0) begin
      @(negedge clk_i);
      out_stall_i = 1'b1;
      repeat (hold_cycles - 1) @(negedge clk_i);
      hold_cycles = 0;
    end
    rx_wait = rx_idle_on ? $urandom_range(0, 7) : 0;
    @(negedge clk_i);
    out_stall_i = (rx_wait != 0);
    if (rx_wait > 1) begin
      repeat (rx_wait - 1) @(negedge clk_i);
    end
    if (rx_wait != 0) begin
      @(negedge clk_i);
      out_stall_i = 1'b0;
    end
    do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
  end

  always @(posedge clk_i) begin
    pick_t exp_pick;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_picks.size() == 0) begin
        if (error_count < 10) begin
          $display("unexpected result: index %0d position %0d last %0b",
                   out_index_o, out_position_o, out_last_o);
        end
        error_count++;
      end else begin
        exp_pick = expected_picks.pop_front();
        if (out_index_o !== exp_pick.index || out_position_o !== exp_pick.position ||
            out_last_o !== exp_pick.last) begin
          if (error_count < 10) begin
            $display("mismatch: expected index %0d position %0d last %0b, got %0d %0d %0b",
                     exp_pick.index, exp_pick.position, exp_pick.last,
                     out_index_o, out_position_o, out_last_o);
          end
          error_count++;
        end
      end
    end
  end

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    in_func_i        = FuncDigest;
    in_digest_word_i = '0;
    out_stall_i      = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    seen_map         = '0;
    pick_count       = '0;
    pick_done        = 1'b0;
    kappa_reg        = KappaReset;
    error_count      = 0;
    items_done       = 0;
    quiet_cycles     = 0;
    hold_cycles      = 0;
    tx_idle_on       = 1'b1;
    rx_idle_on       = 1'b1;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_kappa_extremes();
    test_backpressure();
    test_random_challenges();
    settle();
    repeat (2 * SettleCycles) @(negedge clk_i);

    if (error_count == 0 && expected_picks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
